// ----- design/sip24_pkg.sv -----
// ----------------------------------------------------------------------------
// sip24_pkg
// Shared types, constants and the SipRound function of the SipHash-2-4 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sip24_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 8;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned FinDepth = 6;  // handoff stage plus five round stages

  localparam logic [WordW-1:0] Iv0 = 64'h736F_6D65_7073_6575;
  localparam logic [WordW-1:0] Iv1 = 64'h646F_7261_6E64_6F6D;
  localparam logic [WordW-1:0] Iv2 = 64'h6C79_6765_6E65_7261;
  localparam logic [WordW-1:0] Iv3 = 64'h7465_6462_7974_6573;
  localparam logic [WordW-1:0] FinXor = 64'h0000_0000_0000_00FF;

  // register indexes, taken from paddr[3]
  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
  } lanes_t;

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
  } key_t;

  // lanes at message close plus the final block still to be absorbed
  typedef struct packed {
    lanes_t           lanes;
    logic [WordW-1:0] blk;
  } hand_t;

  function automatic lanes_t lanes_init(input key_t k);
    lanes_t r;
    r.v0 = Iv0 ^ k.k0;
    r.v1 = Iv1 ^ k.k1;
    r.v2 = Iv2 ^ k.k0;
    r.v3 = Iv3 ^ k.k1;
    return r;
  endfunction

  function automatic lanes_t lane_round(input lanes_t a);
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
    lanes_t r;
    v0 = a.v0;
    v1 = a.v1;
    v2 = a.v2;
    v3 = a.v3;
    v0 = v0 + v1;
    v1 = {v1[50:0], v1[63:51]};
    v1 = v1 ^ v0;
    v0 = {v0[31:0], v0[63:32]};
    v2 = v2 + v3;
    v3 = {v3[47:0], v3[63:48]};
    v3 = v3 ^ v2;
    v0 = v0 + v3;
    v3 = {v3[42:0], v3[63:43]};
    v3 = v3 ^ v0;
    v2 = v2 + v1;
    v1 = {v1[46:0], v1[63:47]};
    v1 = v1 ^ v2;
    v2 = {v2[31:0], v2[63:32]};
    r.v0 = v0;
    r.v1 = v1;
    r.v2 = v2;
    r.v3 = v3;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sip24_if.sv -----
// ----------------------------------------------------------------------------
// sip24 channel interfaces
// Valid/ready channels for message words in and tags out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sip24_in_if;
  logic                            valid;
  logic                            ready;
  logic [sip24_pkg::WordW-1:0]     message_word;
  logic [sip24_pkg::CountW-1:0]    word_bytes;
  logic                            last_word;

  modport source (output valid, message_word, word_bytes, last_word, input ready);
  modport sink   (input valid, message_word, word_bytes, last_word, output ready);
endinterface

interface sip24_out_if;
  logic                        valid;
  logic                        ready;
  logic [sip24_pkg::WordW-1:0] tag;

  modport source (output valid, tag, input ready);
  modport sink   (input valid, tag, output ready);
endinterface

`default_nettype wire

// ----- design/sip24_cfg.sv -----
// ----------------------------------------------------------------------------
// sip24_cfg
// APB key registers; flags a write so the lanes reload from the new key.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sip24_pkg::AddrW-1:0] paddr,
  input  wire logic [sip24_pkg::WordW-1:0] pwdata,
  output logic      [sip24_pkg::WordW-1:0] prdata,
  output logic                             pready,
  output sip24_pkg::key_t                  key_o,
  output logic                             key_wr_o
);
  import sip24_pkg::*;

  key_t key_q, key_d;
  logic wr_en;
  logic reg_sel;

  assign pready   = 1'b1;
  assign reg_sel  = paddr[3];
  assign wr_en    = psel & penable & pwrite & pready;
  assign key_wr_o = wr_en;
  // next key value, so a reload in the write cycle already sees the new key
  assign key_o    = key_d;
  assign prdata   = (reg_sel == RegKeyHigh) ? key_q.k1 : key_q.k0;

  always_comb begin
    key_d = key_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegKeyLow:  key_d.k0 = pwdata;
        RegKeyHigh: key_d.k1 = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  a_key_low_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && (reg_sel == RegKeyLow) |=> key_q.k0 == $past(pwdata))
    else $error("key_low not updated by write");

endmodule

`default_nettype wire

// ----- design/sip24_absorb.sv -----
// ----------------------------------------------------------------------------
// sip24_absorb
// Chaining lanes: two SipRounds per full word, length count, final block build.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24_absorb (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sip24_pkg::key_t              key_i,
  input  wire logic                         key_wr_i,
  input  wire logic                         in_fire_i,
  input  wire logic [sip24_pkg::WordW-1:0]  message_word_i,
  input  wire logic [sip24_pkg::CountW-1:0] word_bytes_i,
  input  wire logic                         last_word_i,
  output logic                              hand_valid_o,
  output sip24_pkg::hand_t                  hand_o
);
  import sip24_pkg::*;

  lanes_t           lanes_q, lanes_d;
  logic [LenW-1:0]  len_q, len_d;
  lanes_t           mixed;
  lanes_t           absorbed;
  logic             full_word;
  logic [LenW-1:0]  len_full;
  logic [LenW-1:0]  len_total;
  logic [WordW-1:0] blk;

  // a non-last word, or a last word of 8+ bytes, is absorbed whole here
  assign full_word = !last_word_i || word_bytes_i[3];
  assign len_full  = len_q + LenW'(8);
  assign len_total = full_word ? len_full : len_q + LenW'(word_bytes_i[2:0]);

  always_comb begin
    lanes_t pre;
    pre      = lanes_q;
    pre.v3   = lanes_q.v3 ^ message_word_i;
    mixed    = lane_round(lane_round(pre));
    absorbed = mixed;
    absorbed.v0 = mixed.v0 ^ message_word_i;
  end

  // tail bytes below the count, length in the top byte
  always_comb begin
    blk = '0;
    for (int b = 0; b < 7; b++) begin
      if (!full_word && (CountW'(b) < word_bytes_i)) begin
        blk[8*b +: 8] = message_word_i[8*b +: 8];
      end
    end
    blk[WordW-1 -: LenW] = len_total;
  end

  assign hand_valid_o = in_fire_i && last_word_i;
  assign hand_o.lanes = full_word ? absorbed : lanes_q;
  assign hand_o.blk   = blk;

  always_comb begin
    lanes_d = lanes_q;
    len_d   = len_q;
    priority if (key_wr_i) begin
      lanes_d = lanes_init(key_i);
      len_d   = '0;
    end else if (in_fire_i && last_word_i) begin
      lanes_d = lanes_init(key_i);
      len_d   = '0;
    end else if (in_fire_i) begin
      lanes_d = absorbed;
      len_d   = len_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '{v0: Iv0, v1: Iv1, v2: Iv2, v3: Iv3};
      len_q   <= '0;
    end else begin
      lanes_q <= lanes_d;
      len_q   <= len_d;
    end
  end

  a_len_clear_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && last_word_i) || key_wr_i |=> len_q == '0)
    else $error("length count not cleared at message close");

  a_reload_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && last_word_i && !key_wr_i |=> lanes_q == lanes_init($past(key_i)))
    else $error("lanes not reloaded from key at message close");

endmodule

`default_nettype wire

// ----- design/sip24_final.sv -----
// ----------------------------------------------------------------------------
// sip24_final
// Finalization pipeline: final block absorb, 0xFF xor, four rounds, tag fold.
// One SipRound per stage after the handoff stage; stages collapse bubbles under output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sip24_final (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        hand_valid_i,
  input  wire sip24_pkg::hand_t            hand_i,
  output logic                             take_o,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic      [sip24_pkg::WordW-1:0] tag_o
);
  import sip24_pkg::*;

  lanes_t           st_q  [FinDepth];
  lanes_t           st_d  [FinDepth];
  logic [FinDepth-1:0] vld_q;
  logic [FinDepth:0]   take;
  logic [WordW-1:0] blk0_q, blk1_q;
  logic             out_vld_q;
  logic [WordW-1:0] tag_q;
  lanes_t           last_rnd;

  // a stage can load when empty or when its contents move on
  assign take[FinDepth] = !out_vld_q || out_ready_i;
  for (genvar k = 0; k < FinDepth; k++) begin : g_take
    assign take[k] = !vld_q[k] || take[k+1];
  end

  always_comb begin
    lanes_t pre;
    lanes_t r1;
    st_d[0] = hand_i.lanes;
    pre     = st_q[0];
    pre.v3  = st_q[0].v3 ^ blk0_q;
    st_d[1] = lane_round(pre);
    r1      = lane_round(st_q[1]);
    st_d[2] = r1;
    st_d[2].v0 = r1.v0 ^ blk1_q;
    st_d[2].v2 = r1.v2 ^ FinXor;
    for (int k = 3; k < FinDepth; k++) begin
      st_d[k] = lane_round(st_q[k-1]);
    end
    last_rnd = lane_round(st_q[FinDepth-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take[0]) begin
        vld_q[0] <= hand_valid_i;
      end
      for (int k = 1; k < FinDepth; k++) begin
        if (take[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (take[FinDepth]) begin
        out_vld_q <= vld_q[FinDepth-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < FinDepth; k++) begin
      if (take[k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (take[0]) begin
      blk0_q <= hand_i.blk;
    end
    if (take[1]) begin
      blk1_q <= blk0_q;
    end
    if (take[FinDepth]) begin
      tag_q <= last_rnd.v0 ^ last_rnd.v1 ^ last_rnd.v2 ^ last_rnd.v3;
    end
  end

  assign take_o      = take[0];
  assign out_valid_o = out_vld_q;
  assign tag_o       = tag_q;

  a_hand_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_valid_i |-> take[0])
    else $error("message closed while first stage full");

  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[FinDepth-1] && !take[FinDepth] |=> vld_q[FinDepth-1]
      && $stable(st_q[FinDepth-1]))
    else $error("last round stage lost contents under stall");

endmodule

`default_nettype wire

// ----- design/siphash_2_4_mac_top.sv -----
// ----------------------------------------------------------------------------
// siphash_2_4_mac_top
// SipHash-2-4 MAC engine: 64-bit tag of a word-streamed message, 128-bit key.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Item / access
//  --------  ---  -------------------  ----------------------------------------
//  msg_in    in   valid/ready          message_word, word_bytes, last_word
//  tag_out   out  valid/ready          tag (one per message, on last word)
//  APB       in   psel/penable/pready  key_low @ 0x0, key_high @ 0x8 (64 bit)
//
//  Throughput: one item per cycle while msg_in.ready is high; the chaining lanes
//    run two SipRounds in the cycle a word is taken.
//  Finalization: a tag passes the handoff stage, five single-round stages,
//    then the tag register doing the sixth round + fold.
//  Reset: lanes load from the all-zero key, length count clears, pipe empties.
//  Stalls: a held tag_out backs up the finalization pipe stage by stage;
//    msg_in.ready drops only once the handoff stage is full.
//  A key write reloads the lanes and drops any partial message.
// ----------------------------------------------------------------------------
`default_nettype none

module siphash_2_4_mac_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sip24_pkg::AddrW-1:0] paddr,
  input  wire logic [sip24_pkg::WordW-1:0] pwdata,
  output logic      [sip24_pkg::WordW-1:0] prdata,
  output logic                             pready,
  sip24_in_if.sink                         msg_in,
  sip24_out_if.source                      tag_out
);
  import sip24_pkg::*;

  key_t  key;
  logic  key_wr;
  logic  in_fire;
  logic  hand_valid;
  hand_t hand;
  logic  take0;

  // key registers and the reload strobe
  sip24_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_o    (key),
    .key_wr_o (key_wr)
  );

  // input is held off only when the finalization pipe cannot take a handoff
  assign msg_in.ready = take0;
  assign in_fire      = msg_in.valid && msg_in.ready;

  // chaining lanes: absorb per word, build the final block on the last one
  sip24_absorb u_absorb (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (key),
    .key_wr_i       (key_wr),
    .in_fire_i      (in_fire),
    .message_word_i (msg_in.message_word),
    .word_bytes_i   (msg_in.word_bytes),
    .last_word_i    (msg_in.last_word),
    .hand_valid_o   (hand_valid),
    .hand_o         (hand)
  );

  // closed messages finish here, independent of the next message's words
  sip24_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hand_valid_i (hand_valid),
    .hand_i       (hand),
    .take_o       (take0),
    .out_ready_i  (tag_out.ready),
    .out_valid_o  (tag_out.valid),
    .tag_o        (tag_out.tag)
  );

endmodule

`default_nettype wire
